// ----- src/qei_pkg.sv -----
`default_nettype none

package qei_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int CPR_BITS = 17;
	localparam logic [CPR_BITS-1:0] CPR_RESET = 17'd8192;

	localparam int QUOT_BITS = 15;
	localparam int ANGLE_FULL = 23040;
	localparam int ANGLE_MAX = 23039;
	localparam int BAD_LIMIT = 5;
	localparam int NEAR_DIV = 20;

	// phase along the forward sequence 00,10,11,01 of {a,b}
	function automatic logic [1:0] ab_phase(input logic [1:0] ab);
		logic [1:0] ph;
		case (ab)
			2'b00: ph = 2'd0;
			2'b01: ph = 2'd3;
			2'b10: ph = 2'd1;
			2'b11: ph = 2'd2;
			default: ph = 2'd0;
		endcase
		return ph;
	endfunction

endpackage

`default_nettype wire

// ----- src/qei_div.sv -----
`default_nettype none

module qei_div #(
	parameter int COUNT_BITS = qei_pkg::COUNT_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [COUNT_BITS-1:0]            dividend_hi,
	input  wire logic [qei_pkg::QUOT_BITS-1:0]    dividend_lo,
	input  wire logic [COUNT_BITS:0]              divisor,
	output logic                                  done,
	output logic [qei_pkg::QUOT_BITS-1:0]         quotient
);
	import qei_pkg::*;

	localparam int CNT_BITS = $clog2(QUOT_BITS);

	logic [COUNT_BITS-1:0] rem_q;
	logic [QUOT_BITS-1:0]  qsh_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [COUNT_BITS:0] trial;
	logic [COUNT_BITS:0] diff;
	logic                ge;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	assign trial = {rem_q, qsh_q[QUOT_BITS-1]};
	assign ge    = trial >= divisor;
	assign diff  = trial - divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(QUOT_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend_hi;
			qsh_q <= dividend_lo;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			qsh_q <= {qsh_q[QUOT_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = qsh_q;

endmodule

`default_nettype wire

// ----- src/quadrature_encoder_index_filter.sv -----
// x4 quadrature decoder with index filtering. Each accepted request is one sample of the
// A, B and index pins and yields one result: position, angle in 1/64 degree, index flags,
// the count latched at the last index edge and the index edge total. From acceptance to result a
// sample passes two near-zero checks, the state update, one multiply, and a 15-step restoring
// divider that produces the angle one quotient bit per cycle. in_ready is high only while no
// sample is in work; a finished result may still wait in the output register while the next
// sample is accepted. counts_per_rev is to be written through counts_per_rev_we only while
// idle (the block does not enforce this), and values outside [2, 2^COUNT_BITS] are clamped.
`default_nettype none

module quadrature_encoder_index_filter #(
	parameter int COUNT_BITS = qei_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          counts_per_rev_we,
	input  wire logic [qei_pkg::CPR_BITS-1:0]  counts_per_rev,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          pin_a,
	input  wire logic                          pin_b,
	input  wire logic                          pin_index,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [15:0]                        position_count,
	output logic [14:0]                        angle_sixtyfourths,
	output logic                               index_valid,
	output logic                               index_edge_seen,
	output logic [15:0]                        latched_index_count,
	output logic [31:0]                        index_total
);
	import qei_pkg::*;

	localparam int MW = COUNT_BITS + 1;
	localparam int CW = (MW > CPR_BITS) ? MW : CPR_BITS;
	localparam int EW = MW + 5;
	localparam int PW = COUNT_BITS + QUOT_BITS;
	localparam int XW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_NLO  = 3'd1;
	localparam logic [2:0] S_NHI  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_DST  = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;

	logic [CPR_BITS-1:0]   cpr_q;
	logic [COUNT_BITS-1:0] pos_q;
	logic [1:0]            prev_ab_q;
	logic                  prev_idx_q;
	logic                  found_q;
	logic [2:0]            bad_q;
	logic [COUNT_BITS-1:0] capture_q;
	logic [31:0]           total_q;

	logic [MW-1:0] m_q;
	logic [1:0]    ab_q;
	logic          idx_q;
	logic          near_lo_q;
	logic          near_hi_q;
	logic          edge_q;
	logic          sat_q;
	logic [PW-1:0] product_q;

	logic                  out_valid_q;
	logic [15:0]           out_pos_q;
	logic [14:0]           out_angle_q;
	logic                  out_found_q;
	logic                  out_edge_q;
	logic [15:0]           out_cap_q;
	logic [31:0]           out_total_q;

	// clamp of the configured modulus
	logic [CW-1:0] cpr_x;
	logic [CW-1:0] m_clamp;
	always_comb begin
		cpr_x = CW'(cpr_q);
		if (cpr_x < CW'(2))
			m_clamp = CW'(2);
		else if (cpr_x > (CW'(1) << COUNT_BITS))
			m_clamp = CW'(1) << COUNT_BITS;
		else
			m_clamp = cpr_x;
	end

	// near-zero tests: pre < m/20 and pre > m - m/20, without a divider
	logic [EW-1:0] pre_e;
	logic [EW-1:0] m_e;
	logic [EW-1:0] lo_rhs;
	logic [EW-1:0] hi_rhs;
	assign pre_e  = EW'(pos_q);
	assign m_e    = EW'(m_q);
	assign lo_rhs = EW'(NEAR_DIV) * (pre_e + EW'(1));
	assign hi_rhs = EW'(NEAR_DIV) * (m_e - pre_e + EW'(1));

	// next position from the quadrature step and the index edge
	logic [1:0]            step;
	logic                  edge_now;
	logic [COUNT_BITS-1:0] pos_next;
	logic                  found_next;
	logic [2:0]            bad_next;
	logic [2:0]            bad_inc;
	logic [MW-1:0]         pre_m;
	logic [MW-1:0]         m_dec;
	always_comb begin
		step       = ab_phase(ab_q) - ab_phase(prev_ab_q);
		edge_now   = idx_q && !prev_idx_q;
		pre_m      = MW'(pos_q);
		m_dec      = m_q - MW'(1);
		pos_next   = pos_q;
		found_next = found_q;
		bad_next   = bad_q;
		bad_inc    = bad_q + 3'd1;
		case (step)
			2'd1: pos_next = (pre_m >= m_dec) ? '0 : pos_q + COUNT_BITS'(1);
			2'd3: pos_next = (pos_q == '0 || pre_m >= m_q) ?
				m_dec[COUNT_BITS-1:0] : pos_q - COUNT_BITS'(1);
			default: pos_next = pos_q;
		endcase
		if (edge_now) begin
			if (found_q) begin
				if (near_lo_q || near_hi_q) begin
					pos_next = '0;
					bad_next = '0;
				end else begin
					bad_next = bad_inc;
					if (bad_inc > 3'(BAD_LIMIT))
						found_next = 1'b0;
				end
			end else begin
				pos_next   = '0;
				found_next = 1'b1;
				bad_next   = '0;
			end
		end
	end

	logic                 div_start;
	logic                 div_done;
	logic [QUOT_BITS-1:0] quotient;

	assign div_start = (state_q == S_DST);

	qei_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.dividend_hi(product_q[PW-1:QUOT_BITS]),
		.dividend_lo(product_q[QUOT_BITS-1:0]),
		.divisor    (m_q),
		.done       (div_done),
		.quotient   (quotient)
	);

	logic load_out;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	logic [XW-1:0] pos_x;
	logic [XW-1:0] cap_x;
	assign pos_x = XW'(pos_q);
	assign cap_x = XW'(capture_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cpr_q       <= CPR_RESET;
			pos_q       <= '0;
			prev_ab_q   <= '0;
			prev_idx_q  <= 1'b1;
			found_q     <= 1'b0;
			bad_q       <= '0;
			capture_q   <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (counts_per_rev_we)
				cpr_q <= counts_per_rev;
			if (out_valid_q && out_ready && !load_out)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_NLO;
				end
				S_NLO: state_q <= S_NHI;
				S_NHI: state_q <= S_UPD;
				S_UPD: begin
					pos_q      <= pos_next;
					prev_ab_q  <= ab_q;
					prev_idx_q <= idx_q;
					found_q    <= found_next;
					bad_q      <= bad_next;
					if (edge_now) begin
						capture_q <= pos_q;
						total_q   <= total_q + 32'd1;
					end
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_DST;
				S_DST: state_q <= S_DIV;
				S_DIV: begin
					if (div_done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ab_q  <= {pin_a, pin_b};
					idx_q <= pin_index;
					m_q   <= m_clamp[MW-1:0];
				end
			end
			S_NLO: near_lo_q <= m_e >= lo_rhs;
			S_NHI: near_hi_q <= (pre_m > m_q) || (m_e >= hi_rhs);
			S_UPD: edge_q <= edge_now;
			S_MUL: begin
				product_q <= PW'(pos_q) * PW'(ANGLE_FULL);
				sat_q     <= MW'(pos_q) >= m_q;
			end
			default: ;
		endcase
		if (load_out) begin
			out_pos_q   <= pos_x[15:0];
			out_angle_q <= sat_q ? 15'(ANGLE_MAX) : quotient;
			out_found_q <= found_q;
			out_edge_q  <= edge_q;
			out_cap_q   <= cap_x[15:0];
			out_total_q <= total_q;
		end
	end

	assign in_ready            = (state_q == S_IDLE);
	assign out_valid           = out_valid_q;
	assign position_count      = out_pos_q;
	assign angle_sixtyfourths  = out_angle_q;
	assign index_valid         = out_found_q;
	assign index_edge_seen     = out_edge_q;
	assign latched_index_count = out_cap_q;
	assign index_total         = out_total_q;

endmodule

`default_nettype wire

// ----- src/qei_chk.sv -----
`default_nettype none

module qei_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] position_count,
	input wire logic [14:0] angle_sixtyfourths,
	input wire logic [31:0] index_total
);
	import qei_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(position_count) && $stable(index_total))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while one is in work");

	a_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_sixtyfourths <= 15'(ANGLE_MAX))
		else $error("angle beyond one turn");

endmodule

bind quadrature_encoder_index_filter qei_chk u_qei_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_ready          (in_ready),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.position_count    (position_count),
	.angle_sixtyfourths(angle_sixtyfourths),
	.index_total       (index_total)
);

`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [1:0] STEP_UP = 2'd1;
	localparam logic [1:0] STEP_DOWN = 2'd3;

	typedef enum logic [1:0] {HOLD, FWD, BACK, JUMP} motion_t;

	typedef struct {
		logic [15:0] count;
		logic [14:0] angle;
		logic        locked;
		logic        rise;
		logic [15:0] latch;
		logic [31:0] edges;
	} readout_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic counts_per_rev_we = 1'b0;
	logic [qei_pkg::CPR_BITS-1:0] counts_per_rev = qei_pkg::CPR_RESET;
	logic in_valid = 1'b0;
	logic in_ready;
	logic pin_a = 1'b0;
	logic pin_b = 1'b0;
	logic pin_index = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] position_count;
	logic [14:0] angle_sixtyfourths;
	logic index_valid;
	logic index_edge_seen;
	logic [15:0] latched_index_count;
	logic [31:0] index_total;

	// decoder state as the block should hold it
	logic [16:0] cpr_reg = qei_pkg::CPR_RESET;
	logic [15:0] model_count = '0;
	logic [1:0]  last_ab = 2'b00;
	logic        last_index = 1'b1;
	logic        index_locked = 1'b0;
	logic [2:0]  miss_run = '0;
	logic [15:0] index_latch = '0;
	logic [31:0] index_edges = '0;

	readout_t pending_readouts[$];

	int  hold_gap = 0;
	bit  no_gaps = 1'b0;
	int  stall_left = 0;
	int  quiet_cycles = 0;
	int  n_errors = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_settings = 0;
	int  n_rises = 0;
	int  n_rejected = 0;
	int  n_lost = 0;

	quadrature_encoder_index_filter dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.counts_per_rev_we  (counts_per_rev_we),
		.counts_per_rev     (counts_per_rev),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.pin_a              (pin_a),
		.pin_b              (pin_b),
		.pin_index          (pin_index),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.position_count     (position_count),
		.angle_sixtyfourths (angle_sixtyfourths),
		.index_valid        (index_valid),
		.index_edge_seen    (index_edge_seen),
		.latched_index_count(latched_index_count),
		.index_total        (index_total)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int clamp_modulus(input logic [16:0] value);
		if (value < 17'd2)
			return 2;
		if (value > 17'h10000)
			return 65536;
		return int'(value);
	endfunction

	// position of {a,b} along 00,10,11,01
	function automatic logic [1:0] phase_of_ab(input logic [1:0] ab);
		case (ab)
			2'b00: return 2'd0;
			2'b10: return 2'd1;
			2'b11: return 2'd2;
			default: return 2'd3;
		endcase
	endfunction

	function automatic logic [1:0] ab_of_phase(input logic [1:0] ph);
		case (ph)
			2'd0: return 2'b00;
			2'd1: return 2'b10;
			2'd2: return 2'b11;
			default: return 2'b01;
		endcase
	endfunction

	function automatic readout_t decode_sample(input logic a, input logic b, input logic idx);
		int m;
		int near;
		int pre;
		int nxt;
		logic [1:0] ab;
		logic [1:0] stepc;
		logic rise;
		longint prod;
		readout_t r;
		m = clamp_modulus(cpr_reg);
		near = m / qei_pkg::NEAR_DIV;
		pre = int'(model_count);
		nxt = pre;
		ab = {a, b};
		stepc = phase_of_ab(ab) - phase_of_ab(last_ab);
		rise = idx && !last_index;
		if (stepc == STEP_UP)
			nxt = (pre >= m - 1) ? 0 : pre + 1;
		else if (stepc == STEP_DOWN)
			nxt = (pre == 0 || pre >= m) ? m - 1 : pre - 1;
		if (rise) begin
			index_latch = model_count;
			index_edges = index_edges + 32'd1;
			n_rises++;
			if (index_locked) begin
				if (pre > m - near || pre < near) begin
					nxt = 0;
					miss_run = '0;
				end else begin
					miss_run = miss_run + 3'd1;
					n_rejected++;
					if (miss_run > qei_pkg::BAD_LIMIT) begin
						index_locked = 1'b0;
						n_lost++;
					end
				end
			end else begin
				nxt = 0;
				index_locked = 1'b1;
				miss_run = '0;
			end
		end
		model_count = nxt[15:0];
		last_ab = ab;
		last_index = idx;
		prod = longint'(model_count) * qei_pkg::ANGLE_FULL / m;
		if (prod > qei_pkg::ANGLE_MAX)
			prod = qei_pkg::ANGLE_MAX;
		r.count = model_count;
		r.angle = prod[14:0];
		r.locked = index_locked;
		r.rise = rise;
		r.latch = index_latch;
		r.edges = index_edges;
		return r;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	task automatic send_sample(input logic a, input logic b, input logic idx);
		if (hold_gap > 0)
			repeat (hold_gap) @(posedge clk);
		in_valid <= 1'b1;
		pin_a <= a;
		pin_b <= b;
		pin_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_readouts.push_back(decode_sample(a, b, idx));
		n_sent++;
		// keep valid up when the next request follows at once
		hold_gap = pick_gap();
		if (hold_gap > 0)
			in_valid <= 1'b0;
	endtask

	task automatic release_input();
		if (hold_gap == 0)
			in_valid <= 1'b0;
	endtask

	task automatic move_shaft(input motion_t mv, input logic idx);
		logic [1:0] ph;
		logic [1:0] ab;
		ph = phase_of_ab(last_ab);
		case (mv)
			FWD: ph = ph + 2'd1;
			BACK: ph = ph - 2'd1;
			JUMP: ph = ph + 2'd2;
			default: ;
		endcase
		ab = ab_of_phase(ph);
		send_sample(ab[1], ab[0], idx);
	endtask

	task automatic drain_results();
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_cpr(input logic [16:0] value);
		release_input();
		drain_results();
		counts_per_rev <= value;
		counts_per_rev_we <= 1'b1;
		@(posedge clk);
		counts_per_rev_we <= 1'b0;
		cpr_reg = value;
		n_settings++;
	endtask

	task automatic test_power_up();
		send_sample(1'b0, 1'b0, 1'b1);
		send_sample(1'b1, 1'b1, 1'b1);
		send_sample(1'b1, 1'b0, 1'b0);
		send_sample(1'b1, 1'b1, 1'b1);
		send_sample(1'b0, 1'b1, 1'b0);
	endtask

	task automatic test_modulus_extremes();
		set_cpr(17'd0);
		repeat (3) move_shaft(FWD, 1'b0);
		set_cpr(17'h1FFFF);
		move_shaft(BACK, 1'b0);
		// count now sits at the new modulus, outside its range
		set_cpr(17'd65535);
		move_shaft(HOLD, 1'b0);
		move_shaft(FWD, 1'b0);
		move_shaft(BACK, 1'b0);
		set_cpr(17'd100);
		move_shaft(BACK, 1'b0);
	endtask

	task automatic test_index_window();
		set_cpr(17'd40);
		move_shaft(HOLD, 1'b1);
		move_shaft(BACK, 1'b0);
		move_shaft(HOLD, 1'b1);
		move_shaft(FWD, 1'b0);
		move_shaft(FWD, 1'b1);
		move_shaft(FWD, 1'b0);
		move_shaft(FWD, 1'b0);
		// six misplaced pulses in a row drop the lock
		repeat (6) begin
			move_shaft(HOLD, 1'b1);
			move_shaft(FWD, 1'b0);
		end
		move_shaft(HOLD, 1'b1);
	endtask

	task automatic run_random_phase(input logic [16:0] cpr, input int samples, input bit calm);
		int m;
		int spot;
		int wheel;
		int fwd_pct;
		int r;
		bit wide;
		motion_t mv;
		logic idx;
		set_cpr(cpr);
		no_gaps = calm;
		m = clamp_modulus(cpr);
		spot = $urandom_range(m - 1);
		wheel = $urandom_range(m - 1);
		fwd_pct = $urandom_range(30, 95);
		wide = 1'($urandom_range(1));
		for (int i = 0; i < samples; i++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				send_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				continue;
			end
			r = $urandom_range(99);
			if (r < 12)
				mv = HOLD;
			else if (r < 15)
				mv = JUMP;
			else if ($urandom_range(99) < fwd_pct)
				mv = FWD;
			else
				mv = BACK;
			case (mv)
				FWD: wheel = (wheel + 1) % m;
				BACK: wheel = (wheel + m - 1) % m;
				JUMP: wheel = (wheel + 2) % m;
				default: ;
			endcase
			// index mark sits at a fixed shaft angle, with rare stray pulses
			idx = (wheel == spot) || (wide && wheel == (spot + 1) % m) ||
				($urandom_range(199) == 0);
			move_shaft(mv, idx);
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_random_rotation();
		run_random_phase(17'd20, 200, 1'b0);
		run_random_phase(17'd2, 100, 1'b0);
		run_random_phase(17'd41, 250, 1'b1);
		run_random_phase(17'd1, 60, 1'b0);
		run_random_phase(17'd100, 250, 1'b0);
		run_random_phase(17'd360, 200, 1'b0);
		run_random_phase(17'd8, 150, 1'b1);
		run_random_phase(17'h10000, 60, 1'b0);
		run_random_phase(17'h1FFFF, 40, 1'b0);
		run_random_phase(17'd0, 40, 1'b0);
		run_random_phase(17'd40, 100, 1'b0);
		run_random_phase(17'($urandom_range(3, 3000)), 200, 1'b0);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if (!no_gaps && $urandom_range(99) < 25) begin
			out_ready <= 1'b0;
			stall_left = pick_gap();
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin : check_readout
		readout_t want;
		if (out_valid && out_ready) begin
			if (pending_readouts.size() == 0) begin
				$error("result with none pending: position_count %0d", position_count);
				n_errors++;
			end else begin
				want = pending_readouts.pop_front();
				n_checked++;
				check_field("position_count", 32'(want.count), 32'(position_count));
				check_field("angle_sixtyfourths", 32'(want.angle),
					32'(angle_sixtyfourths));
				check_field("index_valid", 32'(want.locked), 32'(index_valid));
				check_field("index_edge_seen", 32'(want.rise), 32'(index_edge_seen));
				check_field("latched_index_count", 32'(want.latch),
					32'(latched_index_count));
				check_field("index_total", want.edges, index_total);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("** quadrature_encoder_index_filter: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_power_up();
		test_modulus_extremes();
		test_index_window();
		test_random_rotation();
		release_input();
		drain_results();
		$display("Checked %0d of %0d samples across %0d modulus settings.",
			n_checked, n_sent, n_settings);
		$display("Index edges %0d, off-window pulses %0d, index losses %0d.",
			n_rises, n_rejected, n_lost);
		if (n_errors == 0)
			$display("** quadrature_encoder_index_filter: PASSED **");
		else
			$display("** quadrature_encoder_index_filter: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
src/qei_pkg.sv
src/qei_div.sv
src/quadrature_encoder_index_filter.sv
src/qei_chk.sv
bench/tb.sv
